### hdl/assert_macros.svh
// Assertion helper macros shared by the calendar converter RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### hdl/ecal_pkg.sv
// Shared widths, constants, result structs and tables for the calendar converter.
// No dependencies; imported by ecal_tod, ecal_date and epoch_seconds_to_calendar.
package ecal_pkg;

  localparam int EPOCH_W = 64;
  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int MDAY_W  = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 14;
  localparam int WDAY_W  = 3;

  localparam int DAYS_W  = 22;   // day count, up to the last supported day
  localparam int TOD_W   = 17;   // second of day
  localparam int T_W     = 38;   // clamped seconds below the saturation point

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned MAX_DAYS      = 2932896;
  localparam int unsigned LAST_SEC      = 86399;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned DAYS_FROM_1BC = 719527;
  localparam int unsigned MARCH_OFS     = DAYS_FROM_1BC - (31 + 28);
  localparam int unsigned DAYS_PER_400Y = 146097;

  localparam longint unsigned SAT_SECS_L =
    (64'(MAX_DAYS) + 64'd1) * 64'(SECS_PER_DAY);
  localparam logic [EPOCH_W-2:0] SAT_SECS = (EPOCH_W-1)'(SAT_SECS_L);

  // 86400 = 128 * 675
  localparam int DAY_SH     = 7;
  localparam int DIV675_SH  = 41;
  localparam logic [31:0] DIV675_M =
    32'(((64'd1 << DIV675_SH) + 64'd674) / 64'd675);

  localparam int DIV7_SH    = 25;
  localparam logic [22:0] DIV7_M =
    23'(((64'd1 << DIV7_SH) + 64'd6) / 64'd7);

  localparam int DIVYR_SH   = 49;
  localparam logic [31:0] DIVYR_M =
    32'(((64'd1 << DIVYR_SH) + 64'(DAYS_PER_400Y) - 64'd1) / 64'(DAYS_PER_400Y));

  localparam int DIV100_SH  = 21;
  localparam logic [14:0] DIV100_M =
    15'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);

  localparam int DIV400_SH  = 23;
  localparam logic [14:0] DIV400_M =
    15'(((64'd1 << DIV400_SH) + 64'd399) / 64'd400);

  localparam int DIV306_SH  = 21;
  localparam logic [12:0] DIV306_M =
    13'(((64'd1 << DIV306_SH) + 64'd305) / 64'd306);

  localparam int DIV3600_SH = 29;
  localparam logic [17:0] DIV3600_M =
    18'(((64'd1 << DIV3600_SH) + 64'd3599) / 64'd3600);

  localparam int DIV60_SH   = 18;
  localparam logic [12:0] DIV60_M =
    13'(((64'd1 << DIV60_SH) + 64'd59) / 64'd60);

  localparam int ECAL_DATE_LAT = 9;
  localparam int TOD_CALC_LAT  = 4;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } tod_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [MDAY_W-1:0] mday;
    logic [WDAY_W-1:0] wday;
  } date_t;

  // Days from March 1 to the first of a month index (1 = March ... 12 = February next year)
  function automatic logic [8:0] month_start(input logic [MON_W-1:0] mon);
    logic [8:0] res;
    unique case (mon)
      4'd1:    res = 9'd0;
      4'd2:    res = 9'd31;
      4'd3:    res = 9'd61;
      4'd4:    res = 9'd92;
      4'd5:    res = 9'd122;
      4'd6:    res = 9'd153;
      4'd7:    res = 9'd184;
      4'd8:    res = 9'd214;
      4'd9:    res = 9'd245;
      4'd10:   res = 9'd275;
      4'd11:   res = 9'd306;
      4'd12:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

### hdl/ecal_tod.sv
// Time-of-day split: second of day into hour, minute and second.
// Depends on ecal_pkg; latency padded to match ecal_date.
module ecal_tod (
  input  logic                      clk,
  input  logic [ecal_pkg::TOD_W-1:0] in_tod,
  output ecal_pkg::tod_t            out_tod
);
  import ecal_pkg::*;

  localparam int REM_W   = 12;
  localparam int TOD_PAD = ECAL_DATE_LAT - TOD_CALC_LAT;

  logic [34:0]        t1_prod;
  logic [HOUR_W-1:0]  t1_hour_nxt, t1_hour_r, t2_hour_r, t3_hour_r, t4_hour_r;
  logic [TOD_W-1:0]   t1_tod_r;
  logic [REM_W-1:0]   t2_rem_nxt, t2_rem_r, t3_rem_r;
  logic [24:0]        t3_prod;
  logic [MIN_W-1:0]   t3_min_nxt, t3_min_r, t4_min_r;
  logic [SEC_W-1:0]   t4_sec_nxt, t4_sec_r;
  tod_t               dly_r [TOD_PAD];

  assign t1_prod     = 35'(in_tod) * 35'(DIV3600_M);
  assign t1_hour_nxt = t1_prod[DIV3600_SH +: HOUR_W];
  assign t2_rem_nxt  = REM_W'(t1_tod_r - TOD_W'(t1_hour_r * SECS_PER_HOUR));
  assign t3_prod     = 25'(t2_rem_r) * 25'(DIV60_M);
  assign t3_min_nxt  = t3_prod[DIV60_SH +: MIN_W];
  assign t4_sec_nxt  = SEC_W'(t3_rem_r - REM_W'(t3_min_r * 60));

  always_ff @(posedge clk) begin
    t1_hour_r <= t1_hour_nxt;
    t1_tod_r  <= in_tod;
    t2_hour_r <= t1_hour_r;
    t2_rem_r  <= t2_rem_nxt;
    t3_hour_r <= t2_hour_r;
    t3_rem_r  <= t2_rem_r;
    t3_min_r  <= t3_min_nxt;
    t4_hour_r <= t3_hour_r;
    t4_min_r  <= t3_min_r;
    t4_sec_r  <= t4_sec_nxt;
    dly_r[0]  <= '{hour: t4_hour_r, minute: t4_min_r, second: t4_sec_r};
    for (int i = 1; i < TOD_PAD; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  assign out_tod = dly_r[TOD_PAD-1];

endmodule

### hdl/ecal_date.sv
// Day count to weekday, year, month and day of month (March-based Gauss formulas).
// Depends on ecal_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ecal_date (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [ecal_pkg::DAYS_W-1:0] in_days,
  output logic                       out_vld,
  output ecal_pkg::date_t            out_date
);
  import ecal_pkg::*;

  localparam int WQ_W   = 19;
  localparam int YX_W   = 31;
  localparam int YDAY_W = 9;
  localparam int MX_W   = 12;

  logic [ECAL_DATE_LAT-1:0] vld_r;

  // stage 1
  logic [DAYS_W-1:0] d1_wx_r, d1_d_r, d1_dp_r;
  // stage 2
  logic [44:0]       d2_wprod;
  logic [WQ_W-1:0]   d2_wq_r;
  logic [DAYS_W-1:0] d2_wx_r, d2_d_r;
  logic [YX_W-1:0]   d2_yx_r;
  // stage 3
  logic [62:0]       d3_ym;
  logic [YEAR_W-1:0] d3_y_r;
  logic [WDAY_W-1:0] d3_wday_r;
  logic [DAYS_W-1:0] d3_d_r;
  // stage 4
  logic [28:0]       d4_p100, d4_p400;
  logic [6:0]        d4_q100_r;
  logic [4:0]        d4_q400_r;
  logic [DAYS_W-1:0] d4_y365_r, d4_d_r;
  logic [YEAR_W-1:0] d4_y_r;
  logic [WDAY_W-1:0] d4_wday_r;
  // stage 5
  logic [DAYS_W-1:0] d5_base_nxt, d5_base_r, d5_d_r;
  logic              d5_leap_nxt, d5_leap_r;
  logic [YEAR_W-1:0] d5_y_r;
  logic [WDAY_W-1:0] d5_wday_r;
  // stage 6
  logic signed [DAYS_W:0] d6_ydiff;
  logic [YDAY_W-1:0] d6_yday_nxt, d6_yday_r;
  logic [YEAR_W-1:0] d6_y_nxt, d6_y_r;
  logic [WDAY_W-1:0] d6_wday_r;
  // stage 7
  logic [MX_W-1:0]   d7_ys, d7_mx_r;
  logic [YDAY_W-1:0] d7_yday_r;
  logic [YEAR_W-1:0] d7_y_r;
  logic [WDAY_W-1:0] d7_wday_r;
  // stage 8
  logic [24:0]       d8_p306;
  logic [MON_W-1:0]  d8_mon_r;
  logic [YDAY_W-1:0] d8_yday_r;
  logic [YEAR_W-1:0] d8_y_r;
  logic [WDAY_W-1:0] d8_wday_r;
  // stage 9
  logic              d9_late;
  date_t             d9_date_nxt, d9_date_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ECAL_DATE_LAT-2:0], in_vld};
    end
  end

  assign d2_wprod = 45'(d1_wx_r) * 45'(DIV7_M);
  assign d3_ym    = 63'(d2_yx_r) * 63'(DIVYR_M);
  assign d4_p100  = 29'(d3_y_r) * 29'(DIV100_M);
  assign d4_p400  = 29'(d3_y_r) * 29'(DIV400_M);

  assign d5_base_nxt = d4_y365_r + DAYS_W'(d4_y_r >> 2) - DAYS_W'(d4_q100_r)
                     + DAYS_W'(d4_q400_r);
  assign d5_leap_nxt = (d4_y_r[1:0] == 2'b00) &&
                       ((d4_y_r != YEAR_W'(d4_q100_r * 100)) ||
                        (d4_y_r == YEAR_W'(d4_q400_r * 400)));

  assign d6_ydiff = signed'({1'b0, d5_d_r}) - signed'({1'b0, d5_base_r});

  always_comb begin
    if (d6_ydiff[DAYS_W]) begin
      d6_yday_nxt = YDAY_W'(d6_ydiff) + YDAY_W'(365) + YDAY_W'(d5_leap_r);
      d6_y_nxt    = d5_y_r - YEAR_W'(1);
    end else begin
      d6_yday_nxt = YDAY_W'(d6_ydiff);
      d6_y_nxt    = d5_y_r;
    end
  end

  assign d7_ys   = MX_W'(d6_yday_r) + MX_W'(31);
  assign d8_p306 = 25'(d7_mx_r) * 25'(DIV306_M);

  assign d9_late = (d8_yday_r >= YDAY_W'(306));

  always_comb begin
    d9_date_nxt.wday = d8_wday_r;
    d9_date_nxt.mday = MDAY_W'(d8_yday_r - month_start(d8_mon_r) + YDAY_W'(1));
    if (d9_late) begin
      d9_date_nxt.month = d8_mon_r - MON_W'(10);
      d9_date_nxt.year  = d8_y_r + YEAR_W'(1);
    end else begin
      d9_date_nxt.month = d8_mon_r + MON_W'(2);
      d9_date_nxt.year  = d8_y_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_wx_r   <= in_days + DAYS_W'(4);
    d1_d_r    <= in_days + DAYS_W'(MARCH_OFS);
    d1_dp_r   <= in_days + DAYS_W'(MARCH_OFS + 2);

    d2_wq_r   <= d2_wprod[DIV7_SH +: WQ_W];
    d2_wx_r   <= d1_wx_r;
    d2_d_r    <= d1_d_r;
    d2_yx_r   <= YX_W'(d1_dp_r) * YX_W'(400);

    d3_y_r    <= d3_ym[DIVYR_SH +: YEAR_W];
    d3_wday_r <= WDAY_W'(d2_wx_r - DAYS_W'(d2_wq_r * 7));
    d3_d_r    <= d2_d_r;

    d4_q100_r <= d4_p100[DIV100_SH +: 7];
    d4_q400_r <= d4_p400[DIV400_SH +: 5];
    d4_y365_r <= DAYS_W'(d3_y_r) * DAYS_W'(365);
    d4_d_r    <= d3_d_r;
    d4_y_r    <= d3_y_r;
    d4_wday_r <= d3_wday_r;

    d5_base_r <= d5_base_nxt;
    d5_leap_r <= d5_leap_nxt;
    d5_d_r    <= d4_d_r;
    d5_y_r    <= d4_y_r;
    d5_wday_r <= d4_wday_r;

    d6_yday_r <= d6_yday_nxt;
    d6_y_r    <= d6_y_nxt;
    d6_wday_r <= d5_wday_r;

    d7_mx_r   <= MX_W'(d7_ys * MX_W'(10));
    d7_yday_r <= d6_yday_r;
    d7_y_r    <= d6_y_r;
    d7_wday_r <= d6_wday_r;

    d8_mon_r  <= d8_p306[DIV306_SH +: MON_W];
    d8_yday_r <= d7_yday_r;
    d8_y_r    <= d7_y_r;
    d8_wday_r <= d7_wday_r;

    d9_date_r <= d9_date_nxt;
  end

  assign out_vld  = vld_r[ECAL_DATE_LAT-1];
  assign out_date = d9_date_r;

  `ASSERT_CLK(a_yday_range, clk, rst_n, vld_r[5] |-> (d6_yday_r <= YDAY_W'(365)), "day of year out of range")
  `ASSERT_CLK(a_mon_range, clk, rst_n, vld_r[7] |-> (d8_mon_r >= MON_W'(1)) && (d8_mon_r <= MON_W'(12)), "month index out of range")

endmodule

### hdl/epoch_seconds_to_calendar.sv
// Epoch seconds to UTC calendar converter, top level. One transaction enters per
// clock and its result appears on a one-cycle out_valid strobe;
// busy is always low and nothing is held back, so the sink must take every result.
// Results pass the divide-by-constant and Gauss year/month pipeline in ecal_date
// (3 front stages here plus 9 there). Negative inputs give 1970-01-01 00:00:00;
// inputs past 9999-12-31 23:59:59 saturate to that instant.
// Depends on ecal_pkg, ecal_tod, ecal_date and assert_macros.svh.
`include "assert_macros.svh"

module epoch_seconds_to_calendar (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ecal_pkg::EPOCH_W-1:0] in_epoch_seconds,
  output logic                                out_valid,
  output logic [ecal_pkg::SEC_W-1:0]          out_second,
  output logic [ecal_pkg::MIN_W-1:0]          out_minute,
  output logic [ecal_pkg::HOUR_W-1:0]         out_hour,
  output logic [ecal_pkg::MDAY_W-1:0]         out_day_of_month,
  output logic [ecal_pkg::MON_W-1:0]          out_month,
  output logic [ecal_pkg::YEAR_W-1:0]         out_year,
  output logic [ecal_pkg::WDAY_W-1:0]         out_weekday
);
  import ecal_pkg::*;

  logic              s1_neg, s1_sat_nxt;
  logic [T_W-1:0]    s1_t_nxt;
  logic              s1_vld_r, s2_vld_r, s3_vld_r;
  logic              s1_sat_r, s2_sat_r;
  logic [T_W-1:0]    s1_t_r, s2_t_r;
  logic [62:0]       s2_prod;
  logic [DAYS_W-1:0] s2_days_nxt, s2_days_r;
  logic [38:0]       s3_dprod;
  logic [TOD_W-1:0]  s3_tod_nxt, s3_tod_r;
  logic [DAYS_W-1:0] s3_days_nxt, s3_days_r;
  tod_t              tod_res;
  date_t             date_res;

  assign busy = 1'b0;

  assign s1_neg     = in_epoch_seconds[EPOCH_W-1];
  assign s1_sat_nxt = !s1_neg && (in_epoch_seconds[EPOCH_W-2:0] >= SAT_SECS);
  assign s1_t_nxt   = (s1_neg || s1_sat_nxt) ? '0 : in_epoch_seconds[T_W-1:0];

  assign s2_prod     = 63'(s1_t_r[T_W-1:DAY_SH]) * 63'(DIV675_M);
  assign s2_days_nxt = s2_prod[DIV675_SH +: DAYS_W];

  assign s3_dprod = 39'(s2_days_r) * 39'(SECS_PER_DAY);

  always_comb begin
    if (s2_sat_r) begin
      s3_days_nxt = DAYS_W'(MAX_DAYS);
      s3_tod_nxt  = TOD_W'(LAST_SEC);
    end else begin
      s3_days_nxt = s2_days_r;
      s3_tod_nxt  = s2_t_r[TOD_W-1:0] - s3_dprod[TOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_t_r    <= s1_t_nxt;
    s1_sat_r  <= s1_sat_nxt;
    s2_t_r    <= s1_t_r;
    s2_sat_r  <= s1_sat_r;
    s2_days_r <= s2_days_nxt;
    s3_days_r <= s3_days_nxt;
    s3_tod_r  <= s3_tod_nxt;
  end

  ecal_date u_date (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s3_vld_r),
    .in_days  (s3_days_r),
    .out_vld  (out_valid),
    .out_date (date_res)
  );

  ecal_tod u_tod (
    .clk     (clk),
    .in_tod  (s3_tod_r),
    .out_tod (tod_res)
  );

  assign out_second       = tod_res.second;
  assign out_minute       = tod_res.minute;
  assign out_hour         = tod_res.hour;
  assign out_day_of_month = date_res.mday;
  assign out_month        = date_res.month;
  assign out_year         = date_res.year;
  assign out_weekday      = date_res.wday;

  `ASSERT_CLK(a_tod_range, clk, rst_n, out_valid |-> (out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_second <= 6'd59), "time of day out of range")
  `ASSERT_CLK(a_date_range, clk, rst_n, out_valid |-> (out_day_of_month != '0) && (out_weekday <= 3'd6) && (out_year >= 14'd1970) && (out_year <= 14'd9999), "date out of range")
  `ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "result strobe after reset")

endmodule

### dv/tb_top.sv
// Self-checking testbench for epoch_seconds_to_calendar: directed corners, then random epochs.
// Uses its own calendar predictor and a queue of expected dates; depends on ecal_pkg.
`timescale 1ns / 1ps

module tb_top;
  import ecal_pkg::*;

  localparam int RANDOM_N    = 1100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic signed [EPOCH_W-1:0] secs;
    logic [SEC_W-1:0]          second;
    logic [MIN_W-1:0]          minute;
    logic [HOUR_W-1:0]         hour;
    logic [MDAY_W-1:0]         mday;
    logic [MON_W-1:0]          month;
    logic [YEAR_W-1:0]         year;
    logic [WDAY_W-1:0]         wday;
  } dated_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic signed [EPOCH_W-1:0]   in_epoch_seconds = '0;
  logic                        busy;
  logic                        out_valid;
  logic [SEC_W-1:0]            out_second;
  logic [MIN_W-1:0]            out_minute;
  logic [HOUR_W-1:0]           out_hour;
  logic [MDAY_W-1:0]           out_day_of_month;
  logic [MON_W-1:0]            out_month;
  logic [YEAR_W-1:0]           out_year;
  logic [WDAY_W-1:0]           out_weekday;

  logic signed [EPOCH_W-1:0]   epochs_to_send [$];
  dated_t                      dates_due [$];
  int                          accepted = 0;
  int                          directed_n = 0;
  int                          mismatches = 0;
  int                          cycles = 0;

  epoch_seconds_to_calendar u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_second       (out_second),
    .out_minute       (out_minute),
    .out_hour         (out_hour),
    .out_day_of_month (out_day_of_month),
    .out_month        (out_month),
    .out_year         (out_year),
    .out_weekday      (out_weekday)
  );

  always begin
    #2;
    clk = 1'b1;
    #2;
    clk = 1'b0;
  end

  function automatic dated_t calendar_of(input logic signed [EPOCH_W-1:0] secs);
    dated_t            r;
    longint unsigned   t, days, tod, d, yr, mo, md, yu;
    longint            yd;
    bit                leap;
    r.secs = secs;
    t = secs[EPOCH_W-1] ? 64'd0 : 64'(secs);
    days = t / SECS_PER_DAY;
    tod = t % SECS_PER_DAY;
    if (days > MAX_DAYS) begin
      days = MAX_DAYS;
      tod = LAST_SEC;
    end
    r.wday = WDAY_W'((days + 4) % 7);
    r.hour = HOUR_W'(tod / SECS_PER_HOUR);
    tod = tod % SECS_PER_HOUR;
    r.minute = MIN_W'(tod / 60);
    r.second = SEC_W'(tod % 60);
    // day count from March 1 of 1 BC
    d = days - 59 + DAYS_FROM_1BC;
    yr = (d + 2) * 400 / DAYS_PER_400Y;
    yd = longint'(d) - longint'(365 * yr + yr / 4 - yr / 100 + yr / 400);
    if (yd < 0) begin
      leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      yd = 365 + (leap ? 1 : 0) + yd;
      yr = yr - 1;
    end
    yu = yd;
    mo = (yu + 31) * 10 / 306;
    md = yu - (367 * mo / 12 - 30) + 1;
    if (yd >= 306) begin
      yr = yr + 1;
      mo = mo - 10;
    end else begin
      mo = mo + 2;
    end
    r.mday = MDAY_W'(md);
    r.month = MON_W'(mo);
    r.year = YEAR_W'(yr);
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // driver: sender idle rate 13% then 87% then none; holds until drained twice
  always @(posedge clk) begin : drive
    int idle_pct;
    bit go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        dates_due.push_back(calendar_of(in_epoch_seconds));
        accepted++;
      end
      idle_pct = (accepted < directed_n + 375) ? 13 : (accepted < directed_n + 750) ? 87 : 0;
      go = (epochs_to_send.size() != 0) && ($urandom_range(0, 99) >= idle_pct);
      if ((accepted == directed_n || accepted == directed_n + 375) && dates_due.size() != 0)
        go = 1'b0;
      if (start && busy) begin
      end else if (go) begin
        start <= 1'b1;
        in_epoch_seconds <= epochs_to_send.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    dated_t want;
    if (rst_n && out_valid) begin
      if (dates_due.size() == 0) begin
        note_mismatch("result transaction with nothing pending");
      end else begin
        want = dates_due.pop_front();
        if (out_second !== want.second)
          note_mismatch($sformatf("secs=%0d second %0d want %0d", want.secs, out_second,
                                  want.second));
        if (out_minute !== want.minute)
          note_mismatch($sformatf("secs=%0d minute %0d want %0d", want.secs, out_minute,
                                  want.minute));
        if (out_hour !== want.hour)
          note_mismatch($sformatf("secs=%0d hour %0d want %0d", want.secs, out_hour,
                                  want.hour));
        if (out_day_of_month !== want.mday)
          note_mismatch($sformatf("secs=%0d mday %0d want %0d", want.secs, out_day_of_month,
                                  want.mday));
        if (out_month !== want.month)
          note_mismatch($sformatf("secs=%0d month %0d want %0d", want.secs, out_month,
                                  want.month));
        if (out_year !== want.year)
          note_mismatch($sformatf("secs=%0d year %0d want %0d", want.secs, out_year,
                                  want.year));
        if (out_weekday !== want.wday)
          note_mismatch($sformatf("secs=%0d weekday %0d want %0d", want.secs, out_weekday,
                                  want.wday));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin : stimulus
    longint corners [$];
    longint sat_edge;
    longint days;
    longint secs;
    corners = '{
      0, 1, -1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
      59, 60, 3599, 3600, 86399, 86400, -86400,
      68169600,                  // leap day 1972
      946684799, 946684800,      // century rollover 1999/2000
      951782400, 951868800,      // leap day 2000 and the day after
      1709164800,                // leap day 2024
      4102444799,                // last second of 2099
      4107456000, 4107542400,    // 2100 is not leap
      64'h0000_0001_0000_0000,
      253402214400, 253402300799, // last day of 9999, last second
      253402300800               // first saturating second
    };
    foreach (corners[i]) epochs_to_send.push_back(corners[i]);
    directed_n = corners.size();
    sat_edge = 253402300800;
    for (int i = 0; i < RANDOM_N; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
          days = $urandom_range(0, MAX_DAYS);
          secs = days * SECS_PER_DAY + $urandom_range(0, LAST_SEC);
        end
        10, 11, 12, 13: begin
          // near Jan 1 / Mar 1 of a random year, where the year estimate needs fixing
          days = (longint'($urandom_range(0, 8029)) * DAYS_PER_400Y) / 400
                 + $urandom_range(0, 75);
          days = (days >= 3) ? days - 3 : days;
          if (days > MAX_DAYS) days = MAX_DAYS;
          secs = days * SECS_PER_DAY + $urandom_range(0, LAST_SEC);
        end
        14: secs = sat_edge - 100000 + $urandom_range(0, 200000);
        15: secs = {1'b0, 31'($urandom), $urandom};
        16: secs = {1'b1, 31'($urandom), $urandom};
        default: secs = {$urandom, $urandom};
      endcase
      epochs_to_send.push_back(secs);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (epochs_to_send.size() != 0 || start || dates_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (dates_due.size() != 0)
      note_mismatch($sformatf("%0d result transactions never came", dates_due.size()));
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/ecal_pkg.sv
hdl/ecal_tod.sv
hdl/ecal_date.sv
hdl/epoch_seconds_to_calendar.sv
dv/tb_top.sv
